// ===== rtl/dtct_pkg.sv =====
package dtct_pkg;

    localparam int MAX_DIM = 1024;
    localparam int POS_W   = $clog2(MAX_DIM);
    localparam int DIM_W   = 11;
    localparam int LVL_W   = 8;
    localparam int COLOR_W = 24;
    localparam int HIT_W   = 21;
    localparam int SUM_W   = POS_W + HIT_W - 1;
    localparam int CIDX_W  = 3;
    localparam int CDAT_W  = 24;
    localparam int QBIT_W  = $clog2(POS_W);

    localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

    typedef enum logic [CIDX_W-1:0] {
        CFG_THRESHOLD = 3'd0,
        CFG_WIDTH     = 3'd1,
        CFG_HEIGHT    = 3'd2,
        CFG_RMARGIN   = 3'd3,
        CFG_BMARGIN   = 3'd4,
        CFG_DARK      = 3'd5,
        CFG_LIGHT     = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CH_RED   = 2'd0,
        CH_GREEN = 2'd1,
        CH_BLUE  = 2'd2
    } t_chan;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_TINT = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    typedef struct packed {
        logic [LVL_W-1:0] tint_red;
        logic [LVL_W-1:0] tint_green;
        logic [LVL_W-1:0] tint_blue;
        logic             frame_end;
        logic             centroid_valid;
        logic [POS_W-1:0] centroid_col;
        logic [POS_W-1:0] centroid_row;
        logic [HIT_W-1:0] hit_count;
    } t_result;

endpackage

// ===== rtl/dtct_ifs.sv =====
interface dtct_in_if;
    import dtct_pkg::*;

    logic             valid;
    logic             ready;
    logic [LVL_W-1:0] depth_level;

    modport source (output valid, output depth_level, input ready);
    modport sink   (input valid, input depth_level, output ready);
endinterface

interface dtct_out_if;
    import dtct_pkg::*;

    logic             valid;
    logic             ready;
    logic [LVL_W-1:0] tint_red;
    logic [LVL_W-1:0] tint_green;
    logic [LVL_W-1:0] tint_blue;
    logic             frame_end;
    logic             centroid_valid;
    logic [POS_W-1:0] centroid_col;
    logic [POS_W-1:0] centroid_row;
    logic [HIT_W-1:0] hit_count;

    modport source (
        output valid, output tint_red, output tint_green, output tint_blue,
        output frame_end, output centroid_valid, output centroid_col,
        output centroid_row, output hit_count, input ready
    );
    modport sink (
        input valid, input tint_red, input tint_green, input tint_blue,
        input frame_end, input centroid_valid, input centroid_col,
        input centroid_row, input hit_count, output ready
    );
endinterface

interface dtct_cfg_if;
    import dtct_pkg::*;

    logic              valid;
    logic              ready;
    logic [CIDX_W-1:0] index;
    logic [CDAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/depth_threshold_centroid_tint.sv =====
// Channel   Dir  Payload                                            Transfer
// i_pix     in   depth_level                                        valid & ready
// o_res     out  tint_red/green/blue, frame_end, centroid_valid,    valid & ready
//                centroid_col, centroid_row, hit_count
// i_cfg     in   index, data                                        valid & ready
//
// A pixel passes through its transfer, a step for each color channel in turn on the
// shared tint multiply unit, and the load of the output register.
// The last pixel of a frame with hits also passes through the shared restoring
// divider, which produces 10 quotient bits for the column, then 10 for the row.
// Reset is synchronous and active low; it restores the register defaults.
// A stalled output holds the block in its final step; one result may wait in
// the output register while the next pixel is transferred.
module depth_threshold_centroid_tint (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    dtct_in_if.sink              i_pix,
    dtct_out_if.source           o_res,
    dtct_cfg_if.sink             i_cfg
);
    import dtct_pkg::*;

    logic [LVL_W-1:0]   r_thr;
    logic [DIM_W-1:0]   r_width;
    logic [DIM_W-1:0]   r_height;
    logic [DIM_W-1:0]   r_rmargin;
    logic [DIM_W-1:0]   r_bmargin;
    logic [COLOR_W-1:0] r_dark;
    logic [COLOR_W-1:0] r_light;

    t_state             r_state,     n_state;
    logic [POS_W-1:0]   r_col,       n_col;
    logic [POS_W-1:0]   r_row,       n_row;
    logic [SUM_W-1:0]   r_col_sum,   n_col_sum;
    logic [SUM_W-1:0]   r_row_sum,   n_row_sum;
    logic [HIT_W-1:0]   r_hits,      n_hits;
    logic [LVL_W-1:0]   r_level,     n_level;
    logic               r_end,       n_end;
    t_chan              r_chan,      n_chan;
    logic [LVL_W-1:0]   r_tint_red,  n_tint_red;
    logic [LVL_W-1:0]   r_tint_grn,  n_tint_grn;
    logic [LVL_W-1:0]   r_tint_blu,  n_tint_blu;
    logic [SUM_W-1:0]   r_div_rem,   n_div_rem;
    logic [SUM_W-1:0]   r_den_sh,    n_den_sh;
    logic [POS_W-1:0]   r_quot,      n_quot;
    logic [QBIT_W-1:0]  r_bit,       n_bit;
    logic               r_div_row,   n_div_row;
    logic [SUM_W-1:0]   r_row_hold,  n_row_hold;
    logic [HIT_W-1:0]   r_fin_hits,  n_fin_hits;
    logic [POS_W-1:0]   r_col_q,     n_col_q;
    logic               r_out_valid, n_out_valid;
    t_result            r_out,       n_out;

    logic [DIM_W-1:0]   w_clamp;
    logic [DIM_W-1:0]   h_clamp;
    logic               last_col;
    logic               last_row;
    logic               pix_hit;
    logic [SUM_W-1:0]   col_sum_add;
    logic [SUM_W-1:0]   row_sum_add;
    logic [HIT_W-1:0]   hits_add;
    logic               pix_xfer;
    logic [LVL_W-1:0]   ch_dark;
    logic [LVL_W-1:0]   ch_light;
    logic [16:0]        mix;
    logic [16:0]        mix_div;
    logic [LVL_W-1:0]   tint_q;
    logic               div_ge;
    logic [POS_W-1:0]   quot_next;
    logic               has_hits;

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= LVL_W'(20);
            r_width   <= DIM_W'(512);
            r_height  <= DIM_W'(424);
            r_rmargin <= DIM_W'(100);
            r_bmargin <= DIM_W'(10);
            r_dark    <= COLOR_W'(24'hCD9B9B);
            r_light   <= COLOR_W'(24'hFFE4E1);
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_THRESHOLD: r_thr     <= i_cfg.data[LVL_W-1:0];
                CFG_WIDTH:     r_width   <= i_cfg.data[DIM_W-1:0];
                CFG_HEIGHT:    r_height  <= i_cfg.data[DIM_W-1:0];
                CFG_RMARGIN:   r_rmargin <= i_cfg.data[DIM_W-1:0];
                CFG_BMARGIN:   r_bmargin <= i_cfg.data[DIM_W-1:0];
                CFG_DARK:      r_dark    <= i_cfg.data[COLOR_W-1:0];
                CFG_LIGHT:     r_light   <= i_cfg.data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    // pixel position and region test
    always_comb begin
        if (r_width == '0) begin
            w_clamp = DIM_W'(1);
        end else if (r_width > DIM_MAX) begin
            w_clamp = DIM_MAX;
        end else begin
            w_clamp = r_width;
        end
        if (r_height == '0) begin
            h_clamp = DIM_W'(1);
        end else if (r_height > DIM_MAX) begin
            h_clamp = DIM_MAX;
        end else begin
            h_clamp = r_height;
        end
    end

    assign last_col = ({1'b0, r_col} + DIM_W'(1)) >= w_clamp;
    assign last_row = ({1'b0, r_row} + DIM_W'(1)) >= h_clamp;
    assign pix_hit  = (i_pix.depth_level < r_thr)
                   && (({2'b0, r_row} + {1'b0, r_bmargin}) < {1'b0, h_clamp})
                   && (({2'b0, r_col} + {1'b0, r_rmargin}) < {1'b0, w_clamp});

    assign col_sum_add = r_col_sum + (pix_hit ? SUM_W'(r_col) : '0);
    assign row_sum_add = r_row_sum + (pix_hit ? SUM_W'(r_row) : '0);
    assign hits_add    = r_hits + (pix_hit ? HIT_W'(1) : '0);

    assign i_pix.ready = (r_state == S_IDLE);
    assign pix_xfer    = i_pix.valid && i_pix.ready;

    // shared tint unit: floor(x / 255) as (x + (x >> 8) + 1) >> 8
    always_comb begin
        unique case (r_chan)
            CH_RED: begin
                ch_dark  = r_dark[23:16];
                ch_light = r_light[23:16];
            end
            CH_GREEN: begin
                ch_dark  = r_dark[15:8];
                ch_light = r_light[15:8];
            end
            default: begin
                ch_dark  = r_dark[7:0];
                ch_light = r_light[7:0];
            end
        endcase
    end

    assign mix     = 17'(ch_dark) * 17'(LVL_W'(255) - r_level)
                   + 17'(ch_light) * 17'(r_level);
    assign mix_div = mix + (mix >> 8) + 17'd1;
    assign tint_q  = mix_div[15:8];

    // shared restoring divider
    assign div_ge    = r_div_rem >= r_den_sh;
    assign quot_next = {r_quot[POS_W-2:0], div_ge};
    assign has_hits  = (r_fin_hits != '0);

    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_row       = r_row;
        n_col_sum   = r_col_sum;
        n_row_sum   = r_row_sum;
        n_hits      = r_hits;
        n_level     = r_level;
        n_end       = r_end;
        n_chan      = r_chan;
        n_tint_red  = r_tint_red;
        n_tint_grn  = r_tint_grn;
        n_tint_blu  = r_tint_blu;
        n_div_rem   = r_div_rem;
        n_den_sh    = r_den_sh;
        n_quot      = r_quot;
        n_bit       = r_bit;
        n_div_row   = r_div_row;
        n_row_hold  = r_row_hold;
        n_fin_hits  = r_fin_hits;
        n_col_q     = r_col_q;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_res.ready;

        unique case (r_state)
            S_IDLE: begin
                if (pix_xfer) begin
                    n_level = i_pix.depth_level;
                    n_end   = last_col && last_row;
                    n_chan  = CH_RED;
                    n_state = S_TINT;
                    if (last_col && last_row) begin
                        n_div_rem  = col_sum_add;
                        n_row_hold = row_sum_add;
                        n_fin_hits = hits_add;
                        n_col_sum  = '0;
                        n_row_sum  = '0;
                        n_hits     = '0;
                        n_col      = '0;
                        n_row      = '0;
                    end else begin
                        n_col_sum = col_sum_add;
                        n_row_sum = row_sum_add;
                        n_hits    = hits_add;
                        if (last_col) begin
                            n_col = '0;
                            n_row = r_row + POS_W'(1);
                        end else begin
                            n_col = r_col + POS_W'(1);
                        end
                    end
                end
            end
            S_TINT: begin
                unique case (r_chan)
                    CH_RED:   n_tint_red = tint_q;
                    CH_GREEN: n_tint_grn = tint_q;
                    default:  n_tint_blu = tint_q;
                endcase
                if (r_chan == CH_BLUE) begin
                    if (r_end && has_hits) begin
                        n_den_sh  = {r_fin_hits, (POS_W - 1)'(0)};
                        n_bit     = QBIT_W'(POS_W - 1);
                        n_quot    = '0;
                        n_div_row = 1'b0;
                        n_state   = S_DIV;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_chan = t_chan'(r_chan + 2'd1);
                end
            end
            S_DIV: begin
                n_quot   = quot_next;
                n_den_sh = r_den_sh >> 1;
                if (div_ge) begin
                    n_div_rem = r_div_rem - r_den_sh;
                end
                if (r_bit == '0) begin
                    if (!r_div_row) begin
                        n_col_q   = quot_next;
                        n_div_rem = r_row_hold;
                        n_den_sh  = {r_fin_hits, (POS_W - 1)'(0)};
                        n_bit     = QBIT_W'(POS_W - 1);
                        n_quot    = '0;
                        n_div_row = 1'b1;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_bit = r_bit - QBIT_W'(1);
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out.tint_red       = r_tint_red;
                    n_out.tint_green     = r_tint_grn;
                    n_out.tint_blue      = r_tint_blu;
                    n_out.frame_end      = r_end;
                    n_out.centroid_valid = r_end && has_hits;
                    n_out.centroid_col   = (r_end && has_hits) ? r_col_q : '0;
                    n_out.centroid_row   = (r_end && has_hits) ? r_quot : '0;
                    n_out.hit_count      = r_end ? r_fin_hits : '0;
                    n_out_valid          = 1'b1;
                    n_state              = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_col_sum   <= '0;
            r_row_sum   <= '0;
            r_hits      <= '0;
            r_out_valid <= 1'b0;
            r_chan      <= CH_RED;
            r_bit       <= '0;
            r_div_row   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_row       <= n_row;
            r_col_sum   <= n_col_sum;
            r_row_sum   <= n_row_sum;
            r_hits      <= n_hits;
            r_out_valid <= n_out_valid;
            r_chan      <= n_chan;
            r_bit       <= n_bit;
            r_div_row   <= n_div_row;
        end
    end

    always_ff @(posedge i_clk) begin
        r_level    <= n_level;
        r_end      <= n_end;
        r_tint_red <= n_tint_red;
        r_tint_grn <= n_tint_grn;
        r_tint_blu <= n_tint_blu;
        r_div_rem  <= n_div_rem;
        r_den_sh   <= n_den_sh;
        r_quot     <= n_quot;
        r_row_hold <= n_row_hold;
        r_fin_hits <= n_fin_hits;
        r_col_q    <= n_col_q;
        r_out      <= n_out;
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.tint_red       = r_out.tint_red;
    assign o_res.tint_green     = r_out.tint_green;
    assign o_res.tint_blue      = r_out.tint_blue;
    assign o_res.frame_end      = r_out.frame_end;
    assign o_res.centroid_valid = r_out.centroid_valid;
    assign o_res.centroid_col   = r_out.centroid_col;
    assign o_res.centroid_row   = r_out.centroid_row;
    assign o_res.hit_count      = r_out.hit_count;

`ifndef SYNTHESIS
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |=> !i_pix.ready)
        else $error("pixel transfer did not drop ready");

    a_div_has_hits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> has_hits)
        else $error("divider running with zero hits");

    a_centroid_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.frame_end) |->
            (!o_res.centroid_valid && o_res.hit_count == '0
             && o_res.centroid_col == '0 && o_res.centroid_row == '0))
        else $error("centroid fields set away from frame end");

    a_empty_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.frame_end && o_res.hit_count == '0) |->
            !o_res.centroid_valid)
        else $error("centroid valid on an empty region");
`endif

endmodule
